// ----- rtl/utf_pkg.sv -----
// Shared types and constants for the UTF-8 to UTF-16LE transcoder.
package utf_pkg;

    localparam int unsigned ACC_W  = 24;
    localparam int unsigned LEFT_W = 2;

    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_BASE  = 8'hC0;
    localparam logic [7:0] LEAD3_BASE  = 8'hE0;
    localparam logic [7:0] LEAD4_BASE  = 8'hF0;
    localparam logic [7:0] LEAD_BAD    = 8'hF8;

    localparam logic [LEFT_W-1:0] LEFT_NONE  = 2'd0;
    localparam logic [LEFT_W-1:0] LEFT_ONE   = 2'd1;
    localparam logic [LEFT_W-1:0] LEFT_TWO   = 2'd2;
    localparam logic [LEFT_W-1:0] LEFT_THREE = 2'd3;

    typedef struct packed {
        logic [7:0] low_byte;
        logic [7:0] high_byte;
        logic       bad_sequence;
        logic       text_done;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_result res;
    } t_step;

endpackage

// ----- rtl/utf_if.sv -----
// Valid/ready channel interfaces for UTF-8 bytes in and UTF-16 code units out.
interface utf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_text;

    modport source (output valid, output in_byte, output end_of_text, input ready);
    modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface utf_unit_if;
    logic       valid;
    logic       ready;
    logic [7:0] low_byte;
    logic [7:0] high_byte;
    logic       bad_sequence;
    logic       text_done;

    modport source (output valid, output low_byte, output high_byte,
                    output bad_sequence, output text_done, input ready);
    modport sink   (input valid, input low_byte, input high_byte,
                    input bad_sequence, input text_done, output ready);
endinterface

// ----- rtl/utf_dec.sv -----
// Sequence decoder: accumulator, remaining-byte count and error flag per transfer.
module utf_dec (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_in_byte,
    input  logic                i_end_of_text,
    output utf_pkg::t_step      o_step
);

    logic signed [utf_pkg::ACC_W-1:0]  r_acc, n_acc;
    logic        [utf_pkg::LEFT_W-1:0] r_left, n_left;
    logic                              r_doomed, n_doomed;

    logic signed [utf_pkg::ACC_W-1:0]  w_cont;
    logic signed [utf_pkg::ACC_W-1:0]  w_acc_next;
    logic        [utf_pkg::LEFT_W-1:0] w_left_dec;
    logic                              w_bad;

    // byte - 128 is the byte with its top bit flipped, read as signed
    assign w_cont = utf_pkg::ACC_W'($signed({~i_in_byte[7], i_in_byte[6:0]}));
    assign w_acc_next = r_doomed ? r_acc : ((r_acc <<< 6) + w_cont);
    assign w_left_dec = r_left - utf_pkg::LEFT_W'(1);
    assign w_bad = r_doomed || (w_acc_next[utf_pkg::ACC_W-1:16] != '0);

    always_comb begin
        n_acc    = r_acc;
        n_left   = r_left;
        n_doomed = r_doomed;
        o_step   = '0;
        if (r_left == utf_pkg::LEFT_NONE) begin
            priority if (i_in_byte < utf_pkg::ASCII_LIMIT) begin
                o_step.emit          = 1'b1;
                o_step.res.low_byte  = i_in_byte;
                o_step.res.text_done = i_end_of_text;
            end else begin
                priority if (i_in_byte < utf_pkg::LEAD2_BASE) begin
                    n_doomed = 1'b1;
                    n_left   = utf_pkg::LEFT_ONE;
                    n_acc    = '0;
                end else if (i_in_byte < utf_pkg::LEAD3_BASE) begin
                    n_acc  = utf_pkg::ACC_W'(i_in_byte[4:0]);
                    n_left = utf_pkg::LEFT_ONE;
                end else if (i_in_byte < utf_pkg::LEAD4_BASE) begin
                    n_acc  = utf_pkg::ACC_W'(i_in_byte[3:0]);
                    n_left = utf_pkg::LEFT_TWO;
                end else if (i_in_byte < utf_pkg::LEAD_BAD) begin
                    n_acc  = utf_pkg::ACC_W'(i_in_byte[2:0]);
                    n_left = utf_pkg::LEFT_THREE;
                end else begin
                    n_doomed = 1'b1;
                    n_left   = utf_pkg::LEFT_THREE;
                    n_acc    = '0;
                end
                if (i_end_of_text) begin
                    n_acc                   = '0;
                    n_left                  = utf_pkg::LEFT_NONE;
                    n_doomed                = 1'b0;
                    o_step.emit             = 1'b1;
                    o_step.res.bad_sequence = 1'b1;
                    o_step.res.text_done    = 1'b1;
                end
            end
        end else begin
            n_acc  = w_acc_next;
            n_left = w_left_dec;
            if (w_left_dec == utf_pkg::LEFT_NONE) begin
                n_acc                   = '0;
                n_doomed                = 1'b0;
                o_step.emit             = 1'b1;
                o_step.res.bad_sequence = w_bad;
                o_step.res.text_done    = i_end_of_text;
                if (!w_bad) begin
                    o_step.res.low_byte  = w_acc_next[7:0];
                    o_step.res.high_byte = w_acc_next[15:8];
                end
            end else if (i_end_of_text) begin
                n_acc                   = '0;
                n_left                  = utf_pkg::LEFT_NONE;
                n_doomed                = 1'b0;
                o_step.emit             = 1'b1;
                o_step.res.bad_sequence = 1'b1;
                o_step.res.text_done    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_left   <= utf_pkg::LEFT_NONE;
            r_doomed <= 1'b0;
        end else if (i_accept) begin
            r_acc    <= n_acc;
            r_left   <= n_left;
            r_doomed <= n_doomed;
        end
    end

endmodule

// ----- rtl/utf_oreg.sv -----
// Result register: holds one code unit until the receiver takes the transfer.
module utf_oreg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  utf_pkg::t_result  i_res,
    input  logic              i_out_ready,
    output logic              o_valid,
    output utf_pkg::t_result  o_res,
    output logic              o_can_take
);

    logic             r_valid, n_valid;
    utf_pkg::t_result r_res;

    assign o_can_take = !r_valid || i_out_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

// ----- rtl/utf8_to_utf16le_transcoder_core.sv -----
// Top level of the UTF-8 to UTF-16LE transcoder.
//
// Input channel i_in carries one UTF-8 byte per transfer plus end_of_text,
// which marks the last byte of a text. Output channel o_out carries one
// UTF-16 code unit as low_byte and high_byte, with bad_sequence for a
// malformed, out-of-range or truncated sequence and text_done for the
// result that closes the text. Both channels are valid/ready.
// A byte that completes a sequence (or an error) produces its result on
// o_out in the cycle after its transfer; bytes in the middle of a sequence
// produce nothing. One byte is taken every cycle while o_out is not
// stalled: the decoder updates its accumulator in a single pass and the
// result register refills in the same cycle that it drains, so throughput
// is one byte per cycle. When the receiver stalls, the held result stays
// on o_out and i_in.ready drops while a result is held and o_out.ready is
// low, also for bytes that would produce nothing.
// Reset (synchronous, active low) empties the result register and returns
// the decoder to waiting for a lead byte.
module utf8_to_utf16le_transcoder_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    utf_byte_if.sink          i_in,
    utf_unit_if.source        o_out
);

    logic             w_can_take;
    logic             w_accept;
    logic             w_out_valid;
    utf_pkg::t_step   w_step;
    utf_pkg::t_result w_out_res;

    assign i_in.ready = w_can_take;
    assign w_accept   = i_in.valid && w_can_take;

    utf_dec u_dec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_in_byte     (i_in.in_byte),
        .i_end_of_text (i_in.end_of_text),
        .o_step        (w_step)
    );

    utf_oreg u_oreg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept && w_step.emit),
        .i_res       (w_step.res),
        .i_out_ready (o_out.ready),
        .o_valid     (w_out_valid),
        .o_res       (w_out_res),
        .o_can_take  (w_can_take)
    );

    assign o_out.valid        = w_out_valid;
    assign o_out.low_byte     = w_out_res.low_byte;
    assign o_out.high_byte    = w_out_res.high_byte;
    assign o_out.bad_sequence = w_out_res.bad_sequence;
    assign o_out.text_done    = w_out_res.text_done;

endmodule
